/* src/gaoi_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the grid area-of-interest table.
// No dependencies; every other file refers to it by scoped name.
package gaoi_pkg;

  localparam int POS_W    = 16;
  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN   = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   object_id;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     found_id;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic                last;
  } rsp_t;

  // Effective grid settings (zero sizes and counts already forced to one)
  typedef struct packed {
    logic [POS_W-1:0]   origin_x;
    logic [POS_W-1:0]   origin_y;
    logic [POS_W-1:0]   cell_width;
    logic [POS_W-1:0]   cell_height;
    logic [COUNT_W-1:0] cells_across;
    logic [COUNT_W-1:0] cells_down;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] qx;
    logic [POS_W-1:0] qy;
  } div_rsp_t;

endpackage

/* src/gaoi_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on gaoi_pkg for the operand width.
module gaoi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gaoi_pkg::POS_W-1:0] dividend,
  input  logic [gaoi_pkg::POS_W-1:0] divisor,
  output logic                      done,
  output logic [gaoi_pkg::POS_W-1:0] quotient
);

  localparam int W = gaoi_pkg::POS_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic          fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, quo[W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (fits) begin
          rem <= W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[W-1:0];
        end
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/gaoi_engine.sv */
`timescale 1ns / 1ps
// Request sequencer with the cell fill memory and the slot id memory.
// Depends on gaoi_pkg; binning quotients come from two gaoi_div units.
module gaoi_engine #(
  parameter int MAX_CELLS      = 256,
  parameter int SLOTS_PER_CELL = 4,
  parameter int ID_BITS        = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  gaoi_pkg::cfg_t     cfg,
  input  logic               req_valid,
  output logic               req_stall,
  input  gaoi_pkg::req_t     req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output gaoi_pkg::rsp_t     rsp,
  output gaoi_pkg::div_req_t div_req,
  input  gaoi_pkg::div_rsp_t div_rsp
);

  localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SAW = (MAX_CELLS * SLOTS_PER_CELL > 1) ?
                       $clog2(MAX_CELLS * SLOTS_PER_CELL) : 1;
  localparam int FW  = $clog2(SLOTS_PER_CELL + 1);
  localparam int IW  = (ID_BITS < gaoi_pkg::ID_W) ? ID_BITS : gaoi_pkg::ID_W;
  localparam int NW  = 10;  // cell number: at most 31 * 31 + 31
  localparam int WW  = 16;  // wide cell number for compares and addresses
  localparam logic [WW-1:0] MAX_W   = WW'(MAX_CELLS);
  localparam logic [AW-1:0] CLR_END = AW'(MAX_CELLS - 1);
  localparam logic [FW-1:0] SLOTS_W = FW'(SLOTS_PER_CELL);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DIVIDE, S_BIN,
    S_ADD_RD, S_ADD_WR,
    S_RM_FILL_RD, S_RM_FILL, S_RM_RD, S_RM_CMP, S_RM_DONE,
    S_Q_NB, S_Q_FILL, S_Q_RD, S_Q_DATA, S_Q_END,
    S_EMIT
  } state_t;

  state_t state;

  // memories
  logic [FW-1:0] fill_mem [MAX_CELLS];
  logic [IW-1:0] slot_mem [MAX_CELLS * SLOTS_PER_CELL];
  logic          fill_we, fill_re, slot_we, slot_re;
  logic [AW-1:0] fill_wa, fill_ra;
  logic [FW-1:0] fill_wd, fill_rd;
  logic [SAW-1:0] slot_wa, slot_ra;
  logic [IW-1:0] slot_wd, slot_rd;

  // request context
  logic [gaoi_pkg::KIND_W-1:0]   kind_q;
  logic [IW-1:0]                 id_q;
  logic [4:0]                    col, row;
  logic [WW-1:0]                 cell_q;
  logic [WW-1:0]                 nc_q;
  logic [FW-1:0]                 fill_n, idx, keep;
  logic [1:0]                    qr, qc;
  logic                          pend_valid;
  logic [IW-1:0]                 pend_id;
  logic [gaoi_pkg::STATUS_W-1:0] res_status;
  logic [AW-1:0]                 clr_addr;

  logic          accept, can_load, rsp_load;
  logic [WW-1:0] cell_c, nc_c;
  logic [4:0]    nr, ncol;
  logic          nb_skip, nb_last, idx_last;
  logic [WW-1:0] slot_base, nb_base;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign can_load  = !rsp_valid || !rsp_stall;
  assign idx_last  = (FW'(idx + FW'(1)) == fill_n);
  assign nb_last   = (qr == 2'd2) && (qc == 2'd2);
  // a result word is loaded into the output register this cycle
  assign rsp_load  = can_load && ((state == S_Q_DATA && pend_valid) ||
                                  state == S_Q_END || state == S_EMIT);

  // cell of the request and of the current neighbour
  assign cell_c = WW'(NW'(row) * NW'(cfg.cells_across) + NW'(col));
  assign nr     = row + {3'b000, qr} - 5'd1;
  assign ncol   = col + {3'b000, qc} - 5'd1;
  assign nc_c   = WW'(NW'(nr) * NW'(cfg.cells_across) + NW'(ncol));
  assign nb_skip = (qr == 2'd0 && row == 5'd0) ||
                   (qr == 2'd2 && ({1'b0, row} + 6'd1) >= {1'b0, cfg.cells_down}) ||
                   (qc == 2'd0 && col == 5'd0) ||
                   (qc == 2'd2 && ({1'b0, col} + 6'd1) >= {1'b0, cfg.cells_across}) ||
                   (nc_c >= MAX_W);
  assign slot_base = WW'(cell_q * WW'(SLOTS_PER_CELL));
  assign nb_base   = WW'(nc_q * WW'(SLOTS_PER_CELL));

  // divider launch
  assign div_req.start = accept && (req.kind != gaoi_pkg::KIND_NONE) &&
                         (req.pos_x >= cfg.origin_x) && (req.pos_y >= cfg.origin_y);
  assign div_req.dx = req.pos_x - cfg.origin_x;
  assign div_req.dy = req.pos_y - cfg.origin_y;

  // memory port control
  always_comb begin
    fill_we = 1'b0;
    fill_wa = cell_q[AW-1:0];
    fill_wd = '0;
    fill_re = 1'b0;
    fill_ra = cell_q[AW-1:0];
    slot_we = 1'b0;
    slot_wa = SAW'(slot_base + WW'(fill_rd));
    slot_wd = id_q;
    slot_re = 1'b0;
    slot_ra = SAW'(slot_base + WW'(idx));
    unique case (state)
      S_CLEAR: begin
        fill_we = 1'b1;
        fill_wa = clr_addr;
      end
      S_ADD_RD, S_RM_FILL_RD: fill_re = 1'b1;
      S_ADD_WR: begin
        if (fill_rd < SLOTS_W) begin
          fill_we = 1'b1;
          fill_wd = FW'(fill_rd + FW'(1));
          slot_we = 1'b1;
        end
      end
      S_RM_RD: slot_re = 1'b1;
      S_RM_CMP: begin
        slot_wa = SAW'(slot_base + WW'(keep));
        slot_wd = slot_rd;
        slot_we = (slot_rd != id_q);
      end
      S_RM_DONE: begin
        fill_we = 1'b1;
        fill_wd = keep;
      end
      S_Q_NB: begin
        fill_re = !nb_skip;
        fill_ra = nc_c[AW-1:0];
      end
      S_Q_RD: begin
        slot_re = 1'b1;
        slot_ra = SAW'(nb_base + WW'(idx));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (fill_re) fill_rd <= fill_mem[fill_ra];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    if (slot_re) slot_rd <= slot_mem[slot_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) rsp_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_END) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            kind_q <= req.kind;
            id_q   <= req.object_id[IW-1:0];
            if (req.kind != gaoi_pkg::KIND_NONE) begin
              if (div_req.start) begin
                state <= S_DIVIDE;
              end else begin
                res_status <= gaoi_pkg::STATUS_OUTSIDE;
                state      <= S_EMIT;
              end
            end
          end
        end
        S_DIVIDE: begin
          if (div_rsp.done) begin
            col <= div_rsp.qx[4:0];
            row <= div_rsp.qy[4:0];
            if (div_rsp.qx >= gaoi_pkg::POS_W'(cfg.cells_across) ||
                div_rsp.qy >= gaoi_pkg::POS_W'(cfg.cells_down)) begin
              res_status <= gaoi_pkg::STATUS_OUTSIDE;
              state      <= S_EMIT;
            end else begin
              state <= S_BIN;
            end
          end
        end
        S_BIN: begin
          cell_q <= cell_c;
          qr <= 2'd0;
          qc <= 2'd0;
          pend_valid <= 1'b0;
          if (cell_c >= MAX_W) begin
            res_status <= gaoi_pkg::STATUS_OUTSIDE;
            state      <= S_EMIT;
          end else if (kind_q == gaoi_pkg::KIND_ADD) begin
            state <= S_ADD_RD;
          end else if (kind_q == gaoi_pkg::KIND_REMOVE) begin
            state <= S_RM_FILL_RD;
          end else begin
            state <= S_Q_NB;
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          res_status <= (fill_rd < SLOTS_W) ? gaoi_pkg::STATUS_OK : gaoi_pkg::STATUS_FULL;
          state      <= S_EMIT;
        end
        S_RM_FILL_RD: state <= S_RM_FILL;
        S_RM_FILL: begin
          fill_n <= fill_rd;
          idx    <= '0;
          keep   <= '0;
          state  <= (fill_rd == '0) ? S_RM_DONE : S_RM_RD;
        end
        S_RM_RD: state <= S_RM_CMP;
        S_RM_CMP: begin
          if (slot_rd != id_q) keep <= keep + FW'(1);
          idx   <= idx + FW'(1);
          state <= idx_last ? S_RM_DONE : S_RM_RD;
        end
        S_RM_DONE: begin
          res_status <= (keep == fill_n) ? gaoi_pkg::STATUS_NOT_FOUND : gaoi_pkg::STATUS_OK;
          state      <= S_EMIT;
        end
        // walk the neighbourhood in row-major order
        S_Q_NB: begin
          nc_q <= nc_c;
          if (!nb_skip) begin
            state <= S_Q_FILL;
          end else if (nb_last) begin
            state <= S_Q_END;
          end else begin
            qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
            if (qc == 2'd2) qr <= qr + 2'd1;
          end
        end
        S_Q_FILL: begin
          fill_n <= fill_rd;
          idx    <= '0;
          if (fill_rd != '0) begin
            state <= S_Q_RD;
          end else if (nb_last) begin
            state <= S_Q_END;
          end else begin
            qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
            if (qc == 2'd2) qr <= qr + 2'd1;
            state <= S_Q_NB;
          end
        end
        S_Q_RD: state <= S_Q_DATA;
        // hold one id back so the final one can carry last
        S_Q_DATA: begin
          if (!pend_valid || can_load) begin
            if (pend_valid) begin
              rsp_valid <= 1'b1;
              rsp <= '{found_id: gaoi_pkg::ID_W'(pend_id), found: 1'b1,
                       status: gaoi_pkg::STATUS_OK, last: 1'b0};
            end
            pend_valid <= 1'b1;
            pend_id    <= slot_rd;
            idx        <= idx + FW'(1);
            if (!idx_last) begin
              state <= S_Q_RD;
            end else if (nb_last) begin
              state <= S_Q_END;
            end else begin
              qc <= (qc == 2'd2) ? 2'd0 : qc + 2'd1;
              if (qc == 2'd2) qr <= qr + 2'd1;
              state <= S_Q_NB;
            end
          end
        end
        S_Q_END: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            rsp <= '{found_id: pend_valid ? gaoi_pkg::ID_W'(pend_id) : '0,
                     found: pend_valid, status: gaoi_pkg::STATUS_OK, last: 1'b1};
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            rsp_valid <= 1'b1;
            rsp <= '{found_id: '0, found: 1'b0, status: res_status, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/grid_area_of_interest_table_unit.sv */
`timescale 1ns / 1ps
// Top level of the grid area-of-interest table: configuration registers,
// two binning dividers and the request engine. Depends on gaoi_pkg.
//
// One request word is taken at a time. After reset a clearing pass
// empties every cell; requests stall until it ends. Binning runs the
// x and y divisions side by side. A remove takes longer for each
// stored id, a query for each neighbour cell visited and each id
// returned. Positions below the origin skip the divide and go straight
// to the outside result; kind 3 words give no result at all.
// Results leave through a registered output, and stalls there hold the
// engine only when a second result is ready.
module grid_area_of_interest_table_unit #(
  parameter int MAX_CELLS      = 256,
  parameter int SLOTS_PER_CELL = 4,
  parameter int ID_BITS        = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gaoi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gaoi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  gaoi_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output gaoi_pkg::rsp_t                      rsp
);

  logic [gaoi_pkg::POS_W-1:0]   origin_x, origin_y, cell_width, cell_height;
  logic [gaoi_pkg::COUNT_W-1:0] cells_across, cells_down;
  gaoi_pkg::cfg_t     cfg;
  gaoi_pkg::div_req_t div_req;
  gaoi_pkg::div_rsp_t div_rsp;
  logic               done_x, done_y;
  logic [gaoi_pkg::POS_W-1:0] quo_x, quo_y;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_width   <= gaoi_pkg::POS_W'(1);
      cell_height  <= gaoi_pkg::POS_W'(1);
      cells_across <= gaoi_pkg::COUNT_W'(16);
      cells_down   <= gaoi_pkg::COUNT_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        gaoi_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data;
        gaoi_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data;
        gaoi_pkg::REG_CELL_WIDTH:   cell_width   <= cfg_data;
        gaoi_pkg::REG_CELL_HEIGHT:  cell_height  <= cfg_data;
        gaoi_pkg::REG_CELLS_ACROSS: cells_across <= cfg_data[gaoi_pkg::COUNT_W-1:0];
        gaoi_pkg::REG_CELLS_DOWN:   cells_down   <= cfg_data[gaoi_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero sizes and counts act as one
  always_comb begin
    cfg.origin_x     = origin_x;
    cfg.origin_y     = origin_y;
    cfg.cell_width   = (cell_width == '0) ? gaoi_pkg::POS_W'(1) : cell_width;
    cfg.cell_height  = (cell_height == '0) ? gaoi_pkg::POS_W'(1) : cell_height;
    cfg.cells_across = (cells_across == '0) ? gaoi_pkg::COUNT_W'(1) : cells_across;
    cfg.cells_down   = (cells_down == '0) ? gaoi_pkg::COUNT_W'(1) : cells_down;
  end

  gaoi_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_req.start),
    .dividend (div_req.dx),
    .divisor  (cfg.cell_width),
    .done     (done_x),
    .quotient (quo_x)
  );

  // same latency as the x unit, so its done is redundant
  gaoi_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_req.start),
    .dividend (div_req.dy),
    .divisor  (cfg.cell_height),
    .done     (done_y),
    .quotient (quo_y)
  );

  assign div_rsp = '{done: done_x & done_y, qx: quo_x, qy: quo_y};

  gaoi_engine #(
    .MAX_CELLS      (MAX_CELLS),
    .SLOTS_PER_CELL (SLOTS_PER_CELL),
    .ID_BITS        (ID_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for the grid area-of-interest table: directed table, then random
// add/remove/query words checked against an in-bench model of the grid.
// Depends on gaoi_pkg and grid_area_of_interest_table_unit.
module tb_top;

  localparam int CELLS = 256;
  localparam int SLOTS = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gaoi_pkg::CFG_IDX_W-1:0] cfg_index = gaoi_pkg::REG_ORIGIN_X;
  logic [gaoi_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  gaoi_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gaoi_pkg::rsp_t rsp;

  grid_area_of_interest_table_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // grid model state
  logic [15:0] g_ox, g_oy, g_w, g_h;
  logic [4:0] g_across, g_down;
  int unsigned fill_cnt [CELLS];
  logic [15:0] slot_mem [CELLS*SLOTS];

  gaoi_pkg::rsp_t pending_rsp [$];
  int errors = 0;
  bit quiet = 1'b1;  // no receiver stalls or sender gaps while set

  task automatic report(input string what, input gaoi_pkg::rsp_t got,
                        input gaoi_pkg::rsp_t want);
    errors++;
    $display("MISMATCH %s: got id=%h f=%b s=%0d l=%b want id=%h f=%b s=%0d l=%b",
             what, got.found_id, got.found, got.status, got.last,
             want.found_id, want.found, want.status, want.last);
  endtask

  function automatic int unsigned nz(input int unsigned v);
    return v == 0 ? 1 : v;
  endfunction

  function automatic void queue_word(input gaoi_pkg::rsp_t o);
    pending_rsp.insert(pending_rsp.size(), o);
  endfunction

  // Work out the words a request produces and update the grid model.
  function automatic void predict_grid(input gaoi_pkg::req_t r);
    int unsigned across, down, col, row, cell_no, keep, n, nc;
    gaoi_pkg::rsp_t o;
    across = nz(g_across);
    down = nz(g_down);
    o = '0;
    o.last = 1'b1;
    if (r.kind == gaoi_pkg::KIND_NONE) return;
    if (r.pos_x < g_ox || r.pos_y < g_oy) begin
      o.status = gaoi_pkg::STATUS_OUTSIDE; queue_word(o); return;
    end
    col = (r.pos_x - g_ox) / nz(g_w);
    row = (r.pos_y - g_oy) / nz(g_h);
    if (col >= across || row >= down || row * across + col >= CELLS) begin
      o.status = gaoi_pkg::STATUS_OUTSIDE; queue_word(o); return;
    end
    cell_no = row * across + col;
    case (r.kind)
      gaoi_pkg::KIND_ADD: begin
        if (fill_cnt[cell_no] >= SLOTS) o.status = gaoi_pkg::STATUS_FULL;
        else begin
          slot_mem[cell_no*SLOTS + fill_cnt[cell_no]] = r.object_id;
          fill_cnt[cell_no]++;
        end
        queue_word(o);
      end
      gaoi_pkg::KIND_REMOVE: begin
        keep = 0;
        for (int i = 0; i < fill_cnt[cell_no]; i++)
          if (slot_mem[cell_no*SLOTS+i] != r.object_id) begin
            slot_mem[cell_no*SLOTS+keep] = slot_mem[cell_no*SLOTS+i];
            keep++;
          end
        o.status = (keep == fill_cnt[cell_no]) ? gaoi_pkg::STATUS_NOT_FOUND
                                               : gaoi_pkg::STATUS_OK;
        fill_cnt[cell_no] = keep;
        queue_word(o);
      end
      default: begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr < 0 && row == 0) continue;
            if (dr > 0 && row + 1 >= down) continue;
            if (dc < 0 && col == 0) continue;
            if (dc > 0 && col + 1 >= across) continue;
            nc = (row + dr) * across + (col + dc);
            if (nc >= CELLS) continue;
            for (int i = 0; i < fill_cnt[nc]; i++) begin
              o = '0;
              o.found_id = slot_mem[nc*SLOTS+i];
              o.found = 1'b1;
              queue_word(o);
              n++;
            end
          end
        if (n == 0) begin
          o = '0; o.last = 1'b1; queue_word(o);
        end else pending_rsp[pending_rsp.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // Result checking and receiver stalls
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected word", rsp, '0);
      end else begin
        gaoi_pkg::rsp_t want;
        want = pending_rsp.pop_front();
        if (rsp.found_id !== want.found_id) report("found_id", rsp, want);
        if (rsp.found !== want.found) report("found", rsp, want);
        if (rsp.status !== want.status) report("status", rsp, want);
        if (rsp.last !== want.last) report("last", rsp, want);
      end
    end
    rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 30);
  end

  // One register write per cycle; set_grid drops the enable afterwards.
  task automatic write_reg(input logic [gaoi_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      gaoi_pkg::REG_ORIGIN_X: g_ox = val;
      gaoi_pkg::REG_ORIGIN_Y: g_oy = val;
      gaoi_pkg::REG_CELL_WIDTH: g_w = val;
      gaoi_pkg::REG_CELL_HEIGHT: g_h = val;
      gaoi_pkg::REG_CELLS_ACROSS: g_across = val[4:0];
      default: g_down = val[4:0];
    endcase
  endtask

  task automatic set_grid(input logic [15:0] ox, oy, w, h, input logic [4:0] a, d);
    write_reg(gaoi_pkg::REG_ORIGIN_X, ox); write_reg(gaoi_pkg::REG_ORIGIN_Y, oy);
    write_reg(gaoi_pkg::REG_CELL_WIDTH, w); write_reg(gaoi_pkg::REG_CELL_HEIGHT, h);
    write_reg(gaoi_pkg::REG_CELLS_ACROSS, {11'd0, a});
    write_reg(gaoi_pkg::REG_CELLS_DOWN, {11'd0, d});
    cfg_we <= 1'b0;
  endtask

  // Offer one word, with random sender gaps, and wait for acceptance.
  // Valid stays up afterwards until the next word or drain replaces it.
  task automatic send_word(input gaoi_pkg::req_t r);
    while (!quiet && $urandom_range(99) < 30) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1; req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_grid(r);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0 && guard < 100000) begin
      @(posedge clk); guard++;
    end
    if (pending_rsp.size() != 0) begin
      report("missing word", '0, pending_rsp[0]);
      pending_rsp.delete();
    end
    repeat (150) @(posedge clk);  // kind 3 words leave no result to wait for
  endtask

  function automatic gaoi_pkg::req_t mk(input logic [1:0] k, input logic [15:0] id, x, y);
    gaoi_pkg::req_t r;
    r.kind = k; r.object_id = id; r.pos_x = x; r.pos_y = y;
    return r;
  endfunction

  // Random word biased towards the occupied area of the grid.
  function automatic gaoi_pkg::req_t rand_word;
    int unsigned p, sx, sy;
    logic [1:0] k;
    p = $urandom_range(99);
    k = p < 40 ? gaoi_pkg::KIND_ADD : p < 60 ? gaoi_pkg::KIND_REMOVE :
        p < 95 ? gaoi_pkg::KIND_QUERY : gaoi_pkg::KIND_NONE;
    sx = nz(g_w) * (nz(g_across) + 1);
    sy = nz(g_h) * (nz(g_down) + 1);
    if ($urandom_range(9) == 0)
      return mk(k, 16'($urandom), 16'($urandom), 16'($urandom));
    return mk(k, $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(15)),
              16'(g_ox + $urandom_range(sx > 65535 ? 65535 : sx)),
              16'(g_oy + $urandom_range(sy > 65535 ? 65535 : sy)));
  endfunction

  typedef struct {
    gaoi_pkg::req_t r;
    bit typed;
    gaoi_pkg::rsp_t want;
  } dir_row_t;

  initial begin
    dir_row_t dir_rows [$];
    gaoi_pkg::rsp_t got_ok, got_out, got_full, got_nf;
    g_ox = 0; g_oy = 0; g_w = 1; g_h = 1; g_across = 16; g_down = 16;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    got_ok = '{found_id: 16'd0, found: 1'b0, status: gaoi_pkg::STATUS_OK, last: 1'b1};
    got_out = got_ok; got_out.status = gaoi_pkg::STATUS_OUTSIDE;
    got_full = got_ok; got_full.status = gaoi_pkg::STATUS_FULL;
    got_nf = got_ok; got_nf.status = gaoi_pkg::STATUS_NOT_FOUND;

    // directed table at reset settings; typed rows checked by hand as well
    dir_rows = '{
      '{mk(gaoi_pkg::KIND_QUERY, 16'h0, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'hFFFF, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'h0000, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'hFFFF, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'h1234, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'h5555, 16'd0, 16'd0), 1, got_full},
      '{mk(gaoi_pkg::KIND_ADD, 16'hAAAA, 16'd1, 16'd1), 1, got_ok},
      '{mk(gaoi_pkg::KIND_QUERY, 16'hFFFF, 16'd1, 16'd0), 0, got_ok},
      '{mk(gaoi_pkg::KIND_REMOVE, 16'hFFFF, 16'd0, 16'd0), 1, got_ok},
      '{mk(gaoi_pkg::KIND_REMOVE, 16'hFFFF, 16'd0, 16'd0), 1, got_nf},
      '{mk(gaoi_pkg::KIND_QUERY, 16'h0, 16'd0, 16'd1), 0, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'h7, 16'd15, 16'd15), 1, got_ok},
      '{mk(gaoi_pkg::KIND_QUERY, 16'h0, 16'd15, 16'd15), 0, got_ok},
      '{mk(gaoi_pkg::KIND_ADD, 16'h9, 16'd16, 16'd3), 1, got_out},
      '{mk(gaoi_pkg::KIND_QUERY, 16'h9, 16'd3, 16'd16), 1, got_out},
      '{mk(gaoi_pkg::KIND_REMOVE, 16'h9, 16'hFFFF, 16'hFFFF), 1, got_out},
      '{mk(gaoi_pkg::KIND_NONE, 16'hFFFF, 16'd0, 16'd0), 0, got_ok},
      '{mk(gaoi_pkg::KIND_QUERY, 16'h0, 16'd8, 16'd8), 1, got_ok}
    };
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].r);
      if (dir_rows[i].typed && pending_rsp.size() != 0
          && pending_rsp[pending_rsp.size()-1] !== dir_rows[i].want)
        report("table row", pending_rsp[pending_rsp.size()-1], dir_rows[i].want);
    end
    drain();

    // below-origin and zero-size settings
    set_grid(16'd100, 16'd200, 16'd0, 16'd0, 5'd0, 5'd0);
    send_word(mk(gaoi_pkg::KIND_ADD, 16'h42, 16'd99, 16'd200));
    send_word(mk(gaoi_pkg::KIND_ADD, 16'h42, 16'd100, 16'd199));
    send_word(mk(gaoi_pkg::KIND_ADD, 16'h43, 16'd100, 16'd200));
    send_word(mk(gaoi_pkg::KIND_QUERY, 16'h0, 16'd100, 16'd200));
    drain();

    // random phases over several grid settings, busy stretch first
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_grid(16'd0, 16'd0, 16'd1, 16'd1, 5'd16, 5'd16);
        1: set_grid(16'd1000, 16'd50, 16'd7, 16'd3, 5'd5, 5'd4);
        2: set_grid(16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF, 5'd1, 5'd1);
        3: set_grid(16'd0, 16'd0, 16'd4096, 16'd4096, 5'd16, 5'd16);
        4: set_grid(16'd3, 16'd5, 16'd2, 16'd3, 5'd31, 5'd9);
        default: set_grid(16'($urandom), 16'($urandom), 16'($urandom_range(1, 64)),
                          16'($urandom_range(1, 64)), 5'($urandom_range(1, 16)),
                          5'($urandom_range(1, 16)));
      endcase
      for (int i = 0; i < 75; i++) begin
        quiet = (ph == 0 && i < 40);
        send_word(rand_word());
      end
      quiet = 1'b0;
      drain();
    end

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
